// ===== rtl/sme_pkg.sv =====
// Shared opcodes, fault codes, field widths and controller command bundle.
`default_nettype none

package sme_pkg;

  localparam int unsigned ActionW  = 4;
  localparam int unsigned MemAddrW = 10;
  localparam int unsigned ConstW   = 32;
  localparam int unsigned TargetW  = 12;
  localparam int unsigned PcOutW   = 12;
  localparam int unsigned TopOutW  = 32;
  localparam int unsigned FaultW   = 2;

  typedef enum logic [ActionW-1:0] {
    OP_LD  = 4'd0,
    OP_ST  = 4'd1,
    OP_LDC = 4'd2,
    OP_ADD = 4'd3,
    OP_SUB = 4'd4,
    OP_CMP = 4'd5,
    OP_JMP = 4'd6,
    OP_BR  = 4'd7,
    OP_RET = 4'd8
  } sme_op_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_OVER  = 2'd1,
    FAULT_UNDER = 2'd2
  } sme_fault_e;

  typedef struct packed {
    logic capture;  // input transaction taken, memories read this cycle
    logic commit;   // instruction executes, output register loads
  } sme_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/stack_machine_execute.sv =====
// Top level of the stack machine execute unit.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o | action, mem_address, constant_value,
//           |           |                         | target_index
//   out     | output    | out_valid_o/out_ready_i | next_pc, top_value, halted, fault
//
// Each instruction has an accept cycle, which reads the stack and data memories, and then
// an execute cycle, which executes it and loads the output register.
// Execution waits while the output register still holds an untaken result.
// The next transaction can be accepted in the cycle after execution.
// Reset clears pc, stack depth and halt flag; the memories are not cleared.
`default_nettype none

module stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned MEM_DEPTH   = 1024,
  parameter int unsigned PROG_DEPTH  = 4096,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic        [sme_pkg::ActionW-1:0]    action_i,
  input  wire logic        [sme_pkg::MemAddrW-1:0]   mem_address_i,
  input  wire logic signed [sme_pkg::ConstW-1:0]     constant_value_i,
  input  wire logic        [sme_pkg::TargetW-1:0]    target_index_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic             [sme_pkg::PcOutW-1:0]     next_pc_o,
  output logic signed      [sme_pkg::TopOutW-1:0]    top_value_o,
  output logic                                       halted_o,
  output logic             [sme_pkg::FaultW-1:0]     fault_o
);

  sme_pkg::sme_cmd_t cmd;

  sme_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sme_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_DEPTH   (MEM_DEPTH),
    .PROG_DEPTH  (PROG_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .mem_address_i    (mem_address_i),
    .constant_value_i (constant_value_i),
    .target_index_i   (target_index_i),
    .next_pc_o        (next_pc_o),
    .top_value_o      (top_value_o),
    .halted_o         (halted_o),
    .fault_o          (fault_o)
  );

endmodule

`default_nettype wire

// ===== rtl/sme_ctrl.sv =====
// Controller: handshake and sequencing of accept and execute cycles.
`default_nettype none

module sme_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output sme_pkg::sme_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } sme_state_e;

  sme_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.capture  = in_valid_i && in_ready_o;
  // execute only once the output register is free or being drained
  assign cmd_o.commit   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o    = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.capture) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_EXEC) && !in_ready_o)
    else $error("capture did not move to execute");

  a_commit_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("executed instruction produced no result");

  a_exec_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && out_valid_o && !out_ready_i |=> (state_q == ST_EXEC))
    else $error("execute left while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/sme_dpath.sv =====
// Datapath: pc, stack with top register, data memory, ALU and output register.
`default_nettype none

module sme_dpath #(
  parameter int unsigned STACK_DEPTH = 256,
  parameter int unsigned MEM_DEPTH   = 1024,
  parameter int unsigned PROG_DEPTH  = 4096,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire sme_pkg::sme_cmd_t                     cmd_i,
  input  wire logic        [sme_pkg::ActionW-1:0]    action_i,
  input  wire logic        [sme_pkg::MemAddrW-1:0]   mem_address_i,
  input  wire logic signed [sme_pkg::ConstW-1:0]     constant_value_i,
  input  wire logic        [sme_pkg::TargetW-1:0]    target_index_i,
  output logic             [sme_pkg::PcOutW-1:0]     next_pc_o,
  output logic signed      [sme_pkg::TopOutW-1:0]    top_value_o,
  output logic                                       halted_o,
  output logic             [sme_pkg::FaultW-1:0]     fault_o
);

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MAW = $clog2(MEM_DEPTH);
  localparam int unsigned PW  = $clog2(PROG_DEPTH);
  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned RedW = 17;
  localparam int unsigned MemInSpan  = 1 << sme_pkg::MemAddrW;
  localparam int unsigned ProgInSpan = 1 << sme_pkg::TargetW;
  localparam int MemShMax  = (MEM_DEPTH >= MemInSpan) ? 0 : $clog2(MemInSpan / MEM_DEPTH);
  localparam int ProgShMax = (PROG_DEPTH >= ProgInSpan) ? 0 : $clog2(ProgInSpan / PROG_DEPTH);

  // captured instruction
  logic [sme_pkg::ActionW-1:0] act_q;
  logic [MAW-1:0]              addr_q;
  logic [DW-1:0]               cval_q;
  logic [PW-1:0]               tgt_q;

  // architectural state
  logic [PW-1:0] pc_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] top_q;
  logic          halt_q;

  logic [DW-1:0] stk_mem [STACK_DEPTH];
  logic [DW-1:0] stk_rd_q;
  logic [DW-1:0] dm_mem [MEM_DEPTH];
  logic [DW-1:0] dm_rd_q;

  // output register
  logic [sme_pkg::PcOutW-1:0]         next_pc_q;
  logic signed [sme_pkg::TopOutW-1:0] top_out_q;
  logic                               halted_q;
  logic [sme_pkg::FaultW-1:0]         fault_q;

  // wrap of address and target by conditional subtraction of shifted depth
  logic [RedW-1:0] addr_red, tgt_red;
  logic [MAW-1:0]  addr_idx;
  logic [PW-1:0]   tgt_idx;

  always_comb begin
    addr_red = RedW'(mem_address_i);
    for (int k = MemShMax; k >= 0; k--) begin
      if (addr_red >= (RedW'(MEM_DEPTH) << k)) begin
        addr_red = addr_red - (RedW'(MEM_DEPTH) << k);
      end
    end
  end

  always_comb begin
    tgt_red = RedW'(target_index_i);
    for (int k = ProgShMax; k >= 0; k--) begin
      if (tgt_red >= (RedW'(PROG_DEPTH) << k)) begin
        tgt_red = tgt_red - (RedW'(PROG_DEPTH) << k);
      end
    end
  end

  assign addr_idx = MAW'(addr_red);
  assign tgt_idx  = PW'(tgt_red);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      addr_q <= addr_idx;
      cval_q <= DW'(constant_value_i);
      tgt_q  <= tgt_idx;
    end
  end

  // execute
  logic [PW-1:0]       pc_inc, pc_d;
  logic [CW-1:0]       cnt_d;
  logic [DW-1:0]       top_d, alu_res;
  logic                halt_d, stk_we, dm_we;
  sme_pkg::sme_fault_e fault_d;
  logic [SAW-1:0]      stk_rd_idx, stk_wr_idx;

  assign pc_inc     = (pc_q == PW'(PROG_DEPTH - 1)) ? '0 : pc_q + PW'(1);
  assign stk_rd_idx = SAW'(cnt_q - CW'(2));  // entry just below the top
  assign stk_wr_idx = SAW'(cnt_q - CW'(1));  // slot the old top spills into

  always_comb begin
    alu_res = top_q + stk_rd_q;
    if (act_q == sme_pkg::OP_SUB) begin
      alu_res = top_q - stk_rd_q;
    end else if (act_q == sme_pkg::OP_CMP) begin
      if (top_q == stk_rd_q) alu_res = '0;
      else if ($signed(top_q) > $signed(stk_rd_q)) alu_res = DW'(1);
      else alu_res = '1;
    end
  end

  always_comb begin
    pc_d    = pc_inc;
    cnt_d   = cnt_q;
    top_d   = top_q;
    halt_d  = halt_q;
    stk_we  = 1'b0;
    dm_we   = 1'b0;
    fault_d = sme_pkg::FAULT_NONE;
    if (halt_q) begin
      pc_d = pc_q;
    end else begin
      unique case (act_q)
        sme_pkg::OP_LD, sme_pkg::OP_LDC: begin
          if (cnt_q == CW'(STACK_DEPTH)) begin
            fault_d = sme_pkg::FAULT_OVER;
          end else begin
            stk_we = (cnt_q != '0);
            top_d  = (act_q == sme_pkg::OP_LD) ? dm_rd_q : cval_q;
            cnt_d  = cnt_q + CW'(1);
          end
        end
        sme_pkg::OP_ST: begin
          if (cnt_q == '0) begin
            fault_d = sme_pkg::FAULT_UNDER;
          end else begin
            dm_we = 1'b1;
            top_d = stk_rd_q;
            cnt_d = cnt_q - CW'(1);
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: begin
          if (cnt_q < CW'(2)) begin
            fault_d = sme_pkg::FAULT_UNDER;
          end else begin
            top_d = alu_res;
            cnt_d = cnt_q - CW'(1);
          end
        end
        sme_pkg::OP_JMP: begin
          pc_d = tgt_q;
        end
        sme_pkg::OP_BR: begin
          if (cnt_q == '0) begin
            fault_d = sme_pkg::FAULT_UNDER;
          end else if (top_q != '0) begin
            pc_d = tgt_q;
          end
        end
        sme_pkg::OP_RET: begin
          halt_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      cnt_q  <= '0;
      halt_q <= 1'b0;
    end else if (cmd_i.commit) begin
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
      halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      top_q     <= top_d;
      next_pc_q <= sme_pkg::PcOutW'(pc_d);
      top_out_q <= (cnt_d == '0) ? '0 : sme_pkg::TopOutW'($signed(top_d));
      halted_q  <= halt_d;
      fault_q   <= fault_d;
    end
  end

  // stack: read in the capture cycle, written in the execute cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) stk_rd_q <= stk_mem[stk_rd_idx];
    if (cmd_i.commit && stk_we) stk_mem[stk_wr_idx] <= top_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) dm_rd_q <= dm_mem[addr_idx];
    if (cmd_i.commit && dm_we) dm_mem[addr_q] <= top_q;
  end

  assign next_pc_o   = next_pc_q;
  assign top_value_o = top_out_q;
  assign halted_o    = halted_q;
  assign fault_o     = fault_q;

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_fault_keeps_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (fault_d != sme_pkg::FAULT_NONE) |=> cnt_q == $past(cnt_q))
    else $error("faulting instruction changed stack depth");

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q && $stable(pc_q) && $stable(cnt_q))
    else $error("state changed after halt");
`endif

endmodule

`default_nettype wire
